@@ hdl/rhpa_pkg.sv @@
package rhpa_pkg;

	// pipeline depth, input register to output register
	localparam int unsigned NumStages = 10;

	// configuration register indexes
	typedef enum logic [2:0] {
		CfgRed   = 3'd0,
		CfgGreen = 3'd1,
		CfgBlue  = 3'd2,
		CfgHue   = 3'd3,
		CfgSat   = 3'd4,
		CfgVal   = 3'd5
	} cfg_reg_t;

	localparam int unsigned CfgAddrW = 3;
	localparam int unsigned CfgDataW = 10;

	// hue sector bases in degrees
	localparam logic [8:0] HueBaseRed    = 9'd0;
	localparam logic [8:0] HueBaseRedLo  = 9'd300;
	localparam logic [8:0] HueBaseGrn    = 9'd120;
	localparam logic [8:0] HueBaseGrnLo  = 9'd60;
	localparam logic [8:0] HueBaseBlu    = 9'd240;
	localparam logic [8:0] HueBaseBluLo  = 9'd180;
	localparam logic [8:0] HueMax        = 9'd359;

	// reciprocals for the constant divisors, quotient = (n * M) >> K, then fixed by one step
	localparam logic [8:0]  RecipP    = 9'd258;   // ceil(2^17 / 510)
	localparam int unsigned RecipPK   = 17;
	localparam logic [8:0]  RecipQ    = 9'd275;   // ceil(2^23 / 30600)
	localparam int unsigned RecipQK   = 23;
	localparam int unsigned DivP      = 510;
	localparam int unsigned DivQ      = 30600;
	localparam int unsigned HalfQ     = 15300;

	// control bundle from the pipeline controller
	typedef struct packed {
		logic [NumStages-1:0] en;
		logic [NumStages-1:0] vld;
	} pipe_ctrl_t;

	// hsv word handed from the forward half to the back half
	typedef struct packed {
		logic [8:0] hue;
		logic [7:0] sat;
		logic [7:0] val;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} hsv_word_t;

	// clamp a two's complement value in -512..511 to 0..255
	function automatic logic [7:0] clamp_u8(input logic [9:0] x);
		logic [7:0] res;
		if (x[9])
			res = 8'd0;
		else if (x[8])
			res = 8'd255;
		else
			res = x[7:0];
		return res;
	endfunction

endpackage

@@ hdl/rhpa_pipe_ctrl.sv @@
module rhpa_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_stall,
	output logic                in_stall,
	output rhpa_pkg::pipe_ctrl_t ctrl
);
	import rhpa_pkg::*;

	logic [NumStages-1:0] vld_q;
	logic [NumStages-1:0] en;
	logic [NumStages-1:0] vld_prev;

	// a stage loads when it is empty or its word moves on
	assign en[NumStages-1] = !vld_q[NumStages-1] || !out_stall;
	for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	assign vld_prev = {vld_q[NumStages-2:0], in_valid};

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NumStages; k++) begin
				if (en[k])
					vld_q[k] <= vld_prev[k];
			end
		end
	end

	assign in_stall = !en[0];
	assign ctrl.en  = en;
	assign ctrl.vld = vld_q;

endmodule

@@ hdl/rhpa_to_hsv.sv @@
module rhpa_to_hsv (
	input  logic                 clk,
	input  rhpa_pkg::pipe_ctrl_t ctrl,
	input  logic [7:0]           in_red,
	input  logic [7:0]           in_green,
	input  logic [7:0]           in_blue,
	input  logic [8:0]           red_off,
	input  logic [8:0]           green_off,
	input  logic [8:0]           blue_off,
	input  logic [9:0]           hue_off,
	input  logic [8:0]           sat_off,
	input  logic [8:0]           val_off,
	output rhpa_pkg::hsv_word_t  hsv_s5
);
	import rhpa_pkg::*;

	// reciprocal table, ceil(65536 / x) = ceil(2^17 / (2x))
	logic [16:0] recip_tbl [256];
	assign recip_tbl[0] = 17'd0;
	for (genvar i = 1; i < 256; i++) begin : g_recip
		localparam int unsigned RecipVal = (65536 + i - 1) / i;
		assign recip_tbl[i] = 17'(RecipVal);
	end

	// stage 1: rgb offsets and clamp
	logic [7:0] red_s1, green_s1, blue_s1;
	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			red_s1   <= clamp_u8(10'({2'b00, in_red}) + {red_off[8], red_off});
			green_s1 <= clamp_u8(10'({2'b00, in_green}) + {green_off[8], green_off});
			blue_s1  <= clamp_u8(10'({2'b00, in_blue}) + {blue_off[8], blue_off});
		end
	end

	// stage 2: max, min, dividends and reciprocal lookups
	logic [7:0]  mx, mn, dlt, xh;
	logic [1:0]  which;
	logic [8:0]  base;
	logic [7:0]  red_s2, green_s2, blue_s2, mx_s2, d_s2;
	logic [16:0] snum_s2, rm_mx_s2, rm_d_s2;
	logic [14:0] hnum_s2;
	logic [8:0]  base_s2;

	always_comb begin
		mx    = red_s1;
		which = 2'd0;
		if (green_s1 > mx) begin
			mx    = green_s1;
			which = 2'd1;
		end
		if (blue_s1 > mx) begin
			mx    = blue_s1;
			which = 2'd2;
		end
		mn = red_s1;
		if (green_s1 < mn)
			mn = green_s1;
		if (blue_s1 < mn)
			mn = blue_s1;
		dlt = mx - mn;
		case (which)
			2'd0: begin
				if (green_s1 >= blue_s1) begin
					xh   = green_s1 - blue_s1;
					base = HueBaseRed;
				end else begin
					xh   = green_s1 - blue_s1 + dlt;
					base = HueBaseRedLo;
				end
			end
			2'd1: begin
				if (blue_s1 > red_s1) begin
					xh   = blue_s1 - red_s1;
					base = HueBaseGrn;
				end else begin
					xh   = blue_s1 - red_s1 + dlt;
					base = HueBaseGrnLo;
				end
			end
			default: begin
				if (red_s1 > green_s1) begin
					xh   = red_s1 - green_s1;
					base = HueBaseBlu;
				end else begin
					xh   = red_s1 - green_s1 + dlt;
					base = HueBaseBluLo;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
			mx_s2    <= mx;
			d_s2     <= dlt;
			snum_s2  <= 17'(dlt) * 17'd510 + 17'(mx);
			hnum_s2  <= 15'(xh) * 15'd120 + 15'(dlt);
			base_s2  <= base;
			rm_mx_s2 <= recip_tbl[mx];
			rm_d_s2  <= recip_tbl[dlt];
		end
	end

	// stage 3: reciprocal multiply, estimate may be one high
	logic [33:0] sprod;
	logic [31:0] hprod;
	logic [7:0]  red_s3, green_s3, blue_s3, mx_s3, d_s3;
	logic [16:0] snum_s3;
	logic [14:0] hnum_s3;
	logic [8:0]  base_s3, sq_s3, hq_s3;

	assign sprod = 34'(snum_s2) * 34'(rm_mx_s2);
	assign hprod = 32'(hnum_s2) * 32'(rm_d_s2);

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
			mx_s3    <= mx_s2;
			d_s3     <= d_s2;
			snum_s3  <= snum_s2;
			hnum_s3  <= hnum_s2;
			base_s3  <= base_s2;
			sq_s3    <= sprod[25:17];
			hq_s3    <= hprod[25:17];
		end
	end

	// stage 4: quotient correction, hue and saturation
	logic [17:0] sback;
	logic [15:0] hback;
	logic [7:0]  sat_c;
	logic [8:0]  hq_c;
	logic [9:0]  hue_c;
	logic [7:0]  red_s4, green_s4, blue_s4, sat_s4, val_s4;
	logic [9:0]  hue_s4;

	assign sback = 18'(sq_s3) * 18'({mx_s3, 1'b0});
	assign hback = 16'(hq_s3) * 16'({d_s3, 1'b0});

	always_comb begin
		if (18'(snum_s3) < sback)
			sat_c = 8'(sq_s3 - 9'd1);
		else
			sat_c = sq_s3[7:0];
		if (16'(hnum_s3) < hback)
			hq_c = hq_s3 - 9'd1;
		else
			hq_c = hq_s3;
		// achromatic pixel gets hue -1
		if (sat_c == 8'd0 || d_s3 == 8'd0)
			hue_c = '1;
		else
			hue_c = 10'(base_s3) + 10'(hq_c);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			red_s4   <= red_s3;
			green_s4 <= green_s3;
			blue_s4  <= blue_s3;
			sat_s4   <= sat_c;
			val_s4   <= mx_s3;
			hue_s4   <= hue_c;
		end
	end

	// stage 5: hsv offsets and clamps
	logic [10:0] hsum;
	logic [8:0]  hue_cl;

	assign hsum = {hue_s4[9], hue_s4} + {hue_off[9], hue_off};

	always_comb begin
		if (hsum[10])
			hue_cl = 9'd0;
		else if (hsum > 11'(HueMax))
			hue_cl = HueMax;
		else
			hue_cl = hsum[8:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			hsv_s5.hue   <= hue_cl;
			hsv_s5.sat   <= clamp_u8(10'({2'b00, sat_s4}) + {sat_off[8], sat_off});
			hsv_s5.val   <= clamp_u8(10'({2'b00, val_s4}) + {val_off[8], val_off});
			hsv_s5.red   <= red_s4;
			hsv_s5.green <= green_s4;
			hsv_s5.blue  <= blue_s4;
		end
	end

endmodule

@@ hdl/rhpa_to_rgb.sv @@
module rhpa_to_rgb (
	input  logic                 clk,
	input  rhpa_pkg::pipe_ctrl_t ctrl,
	input  rhpa_pkg::hsv_word_t  hsv_s5,
	input  logic                 hsv_on,
	output logic [7:0]           red_s10,
	output logic [7:0]           green_s10,
	output logic [7:0]           blue_s10
);
	import rhpa_pkg::*;

	// stage 6: sector and fraction
	logic [2:0]  sec;
	logic [8:0]  sec_base;
	logic [2:0]  sec_s6;
	logic [5:0]  f_s6;
	logic [7:0]  sinv_s6, sat_s6, val_s6, red_s6, green_s6, blue_s6;

	always_comb begin
		if (hsv_s5.hue >= 9'd300) begin
			sec = 3'd5; sec_base = 9'd300;
		end else if (hsv_s5.hue >= 9'd240) begin
			sec = 3'd4; sec_base = 9'd240;
		end else if (hsv_s5.hue >= 9'd180) begin
			sec = 3'd3; sec_base = 9'd180;
		end else if (hsv_s5.hue >= 9'd120) begin
			sec = 3'd2; sec_base = 9'd120;
		end else if (hsv_s5.hue >= 9'd60) begin
			sec = 3'd1; sec_base = 9'd60;
		end else begin
			sec = 3'd0; sec_base = 9'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[5]) begin
			sec_s6   <= sec;
			f_s6     <= 6'(hsv_s5.hue - sec_base);
			sinv_s6  <= 8'd255 - hsv_s5.sat;
			sat_s6   <= hsv_s5.sat;
			val_s6   <= hsv_s5.val;
			red_s6   <= hsv_s5.red;
			green_s6 <= hsv_s5.green;
			blue_s6  <= hsv_s5.blue;
		end
	end

	// stage 7: saturation times fraction
	logic [2:0]  sec_s7;
	logic [13:0] sf_s7, sg_s7;
	logic [7:0]  sinv_s7, val_s7, red_s7, green_s7, blue_s7;
	logic        grey_s7;

	always_ff @(posedge clk) begin
		if (ctrl.en[6]) begin
			sec_s7   <= sec_s6;
			sf_s7    <= 14'(sat_s6) * 14'(f_s6);
			sg_s7    <= 14'(sat_s6) * 14'(6'd60 - f_s6);
			sinv_s7  <= sinv_s6;
			val_s7   <= val_s6;
			grey_s7  <= (sat_s6 == 8'd0);
			red_s7   <= red_s6;
			green_s7 <= green_s6;
			blue_s7  <= blue_s6;
		end
	end

	// stage 8: rounded dividends for p, q and t
	logic [2:0]  sec_s8;
	logic [16:0] np_s8;
	logic [22:0] nq_s8, nt_s8;
	logic [7:0]  val_s8, red_s8, green_s8, blue_s8;
	logic        grey_s8;

	always_ff @(posedge clk) begin
		if (ctrl.en[7]) begin
			sec_s8   <= sec_s7;
			np_s8    <= 17'(val_s7) * 17'(sinv_s7) * 17'd2 + 17'd255;
			nq_s8    <= 23'(val_s7) * 23'(14'(HalfQ) - sf_s7) * 23'd2 + 23'(HalfQ);
			nt_s8    <= 23'(val_s7) * 23'(14'(HalfQ) - sg_s7) * 23'd2 + 23'(HalfQ);
			val_s8   <= val_s7;
			grey_s8  <= grey_s7;
			red_s8   <= red_s7;
			green_s8 <= green_s7;
			blue_s8  <= blue_s7;
		end
	end

	// stage 9: reciprocal multiply by the constant divisors
	logic [25:0] pprod;
	logic [31:0] qprod, tprod;
	logic [2:0]  sec_s9;
	logic [16:0] np_s9;
	logic [22:0] nq_s9, nt_s9;
	logic [8:0]  pe_s9, qe_s9, te_s9;
	logic [7:0]  val_s9, red_s9, green_s9, blue_s9;
	logic        grey_s9;

	assign pprod = 26'(np_s8) * 26'(RecipP);
	assign qprod = 32'(nq_s8) * 32'(RecipQ);
	assign tprod = 32'(nt_s8) * 32'(RecipQ);

	always_ff @(posedge clk) begin
		if (ctrl.en[8]) begin
			sec_s9   <= sec_s8;
			np_s9    <= np_s8;
			nq_s9    <= nq_s8;
			nt_s9    <= nt_s8;
			pe_s9    <= pprod[RecipPK+8:RecipPK];
			qe_s9    <= qprod[RecipQK+8:RecipQK];
			te_s9    <= tprod[RecipQK+8:RecipQK];
			val_s9   <= val_s8;
			grey_s9  <= grey_s8;
			red_s9   <= red_s8;
			green_s9 <= green_s8;
			blue_s9  <= blue_s8;
		end
	end

	// stage 10: quotient correction and sector select
	logic [7:0] pv, qv, tv;
	logic [7:0] ro, go, bo;

	always_comb begin
		if (18'(np_s9) < 18'(pe_s9) * 18'(DivP))
			pv = 8'(pe_s9 - 9'd1);
		else
			pv = pe_s9[7:0];
		if (24'(nq_s9) < 24'(qe_s9) * 24'(DivQ))
			qv = 8'(qe_s9 - 9'd1);
		else
			qv = qe_s9[7:0];
		if (24'(nt_s9) < 24'(te_s9) * 24'(DivQ))
			tv = 8'(te_s9 - 9'd1);
		else
			tv = te_s9[7:0];

		case (sec_s9)
			3'd0: begin ro = val_s9; go = tv;     bo = pv;     end
			3'd1: begin ro = qv;     go = val_s9; bo = pv;     end
			3'd2: begin ro = pv;     go = val_s9; bo = tv;     end
			3'd3: begin ro = pv;     go = qv;     bo = val_s9; end
			3'd4: begin ro = tv;     go = pv;     bo = val_s9; end
			default: begin ro = val_s9; go = pv;  bo = qv;     end
		endcase

		// zero saturation gives grey at the value
		if (grey_s9) begin
			ro = val_s9;
			go = val_s9;
			bo = val_s9;
		end
		// no hsv offsets: clamped rgb passes through
		if (!hsv_on) begin
			ro = red_s9;
			go = green_s9;
			bo = blue_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[9]) begin
			red_s10   <= ro;
			green_s10 <= go;
			blue_s10  <= bo;
		end
	end

endmodule

@@ hdl/rgb_hsv_pixel_adjust.sv @@
// rgb/hsv pixel adjust, ten stage pipeline
// throughput: one word per cycle while the output does not stall; a stall on the output fills empty stages first
// the per-stage valid chain and the reciprocal multiplies set the depth
// reset: arst_n clears all valid bits and all offset registers to zero
module rgb_hsv_pixel_adjust (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_red,
	input  logic [7:0]                    in_green,
	input  logic [7:0]                    in_blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_blue,
	input  logic                          cfg_we,
	input  logic [rhpa_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [rhpa_pkg::CfgDataW-1:0] cfg_wdata
);
	import rhpa_pkg::*;

	logic [8:0] red_off_q, green_off_q, blue_off_q, sat_off_q, val_off_q;
	logic [9:0] hue_off_q;
	logic       hsv_on;
	pipe_ctrl_t ctrl;
	hsv_word_t  hsv_s5;

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_off_q   <= '0;
			green_off_q <= '0;
			blue_off_q  <= '0;
			hue_off_q   <= '0;
			sat_off_q   <= '0;
			val_off_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				CfgRed:   red_off_q   <= cfg_wdata[8:0];
				CfgGreen: green_off_q <= cfg_wdata[8:0];
				CfgBlue:  blue_off_q  <= cfg_wdata[8:0];
				CfgHue:   hue_off_q   <= cfg_wdata;
				CfgSat:   sat_off_q   <= cfg_wdata[8:0];
				CfgVal:   val_off_q   <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	assign hsv_on = (|hue_off_q) || (|sat_off_q) || (|val_off_q);

	rhpa_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.ctrl      (ctrl)
	);

	rhpa_to_hsv u_to_hsv (
		.clk       (clk),
		.ctrl      (ctrl),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.red_off   (red_off_q),
		.green_off (green_off_q),
		.blue_off  (blue_off_q),
		.hue_off   (hue_off_q),
		.sat_off   (sat_off_q),
		.val_off   (val_off_q),
		.hsv_s5    (hsv_s5)
	);

	rhpa_to_rgb u_to_rgb (
		.clk       (clk),
		.ctrl      (ctrl),
		.hsv_s5    (hsv_s5),
		.hsv_on    (hsv_on),
		.red_s10   (out_red),
		.green_s10 (out_green),
		.blue_s10  (out_blue)
	);

	assign out_valid = ctrl.vld[NumStages-1];

endmodule

@@ hdl/rhpa_checker.sv @@
module rhpa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);
	import rhpa_pkg::*;

	// in reset no output word is shown
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// an empty or draining output stage lets every stage move
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while output can drain");

	// after reset no word comes out before the pipe has filled
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid [*NumStages])
		else $error("output word earlier than the pipe depth");

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_red)
		&& $stable(out_green) && $stable(out_blue)))
		else $error("stalled output word changed");

endmodule

bind rgb_hsv_pixel_adjust rhpa_checker u_rhpa_checker (.*);
